[rtl/gasp_pkg.sv]
// Package for the glyph atlas shelf packer: sizes, codes, FSM state,
// and controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gasp_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int MAX_DIM     = 512;

    localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
    localparam int DIM_AW   = $clog2(MAX_DIM);
    localparam int PIX_AW   = 2 * DIM_AW;
    localparam int PIX_DEPTH = MAX_DIM * MAX_DIM;

    localparam int FIELD_W  = 10;
    localparam int CP_W     = 21;
    localparam int PIXV_W   = 8;
    localparam int POS_W    = 9;
    localparam int IDX_W    = 12;
    localparam int ENTRY_W  = CP_W + 2 * POS_W + 2 * FIELD_W;

    localparam logic [FIELD_W-1:0] DIM_LIMIT = FIELD_W'(MAX_DIM);

    localparam logic REG_ATLAS_W = 1'b0;
    localparam logic REG_ATLAS_H = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PLACE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic latch_place;
        logic pixel_step;
        logic place_exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_sts;

    function automatic logic [FIELD_W-1:0] clamp_dim(input logic [FIELD_W-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

endpackage
`default_nettype wire

[rtl/glyph_atlas_shelf_packer.sv]
// Glyph atlas shelf packer top level: APB register file, controller, datapath.
// Place item: after acceptance, placement and the result register update in S_PLACE;
//   the result is valid in S_RESP, and no item is accepted until it is taken.
// Pixel item: one per cycle while idle, written to the pixel store in the next cycle if in an active fill and in range.
// Reset: synchronous; a clearing pass zeroes the 262144-byte pixel store,
//   one byte per cycle, with input ready low. APB writes always taken.
`timescale 1ns / 1ps
`default_nettype none
module glyph_atlas_shelf_packer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [2:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_operation,
    input  wire logic [gasp_pkg::CP_W-1:0]      i_codepoint,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_glyph_width,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_glyph_height,
    input  wire logic [gasp_pkg::PIXV_W-1:0]    i_pixel_value,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [1:0]                          o_status,
    output logic [gasp_pkg::POS_W-1:0]          o_place_x,
    output logic [gasp_pkg::POS_W-1:0]          o_place_y,
    output logic [gasp_pkg::IDX_W-1:0]          o_glyph_index
);

    logic [gasp_pkg::FIELD_W-1:0] r_atlas_w, r_atlas_h;
    logic                         cfg_wr;
    gasp_pkg::t_cmd               cmd;
    gasp_pkg::t_sts               sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= gasp_pkg::DIM_LIMIT;
            r_atlas_h <= gasp_pkg::DIM_LIMIT;
        end else if (cfg_wr) begin
            if (paddr[2] == gasp_pkg::REG_ATLAS_W) begin
                r_atlas_w <= pwdata[gasp_pkg::FIELD_W-1:0];
            end else begin
                r_atlas_h <= pwdata[gasp_pkg::FIELD_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == gasp_pkg::REG_ATLAS_W) begin
            prdata[gasp_pkg::FIELD_W-1:0] = r_atlas_w;
        end else begin
            prdata[gasp_pkg::FIELD_W-1:0] = r_atlas_h;
        end
    end

    gasp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gasp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_atlas_width  (r_atlas_w),
        .i_atlas_height (r_atlas_h),
        .i_codepoint    (i_codepoint),
        .i_glyph_width  (i_glyph_width),
        .i_glyph_height (i_glyph_height),
        .i_pixel_value  (i_pixel_value),
        .o_status       (o_status),
        .o_place_x      (o_place_x),
        .o_place_y      (o_place_y),
        .o_glyph_index  (o_glyph_index)
    );

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_place_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == gasp_pkg::OP_PLACE)
        |=> !o_in_ready ##1 o_out_valid)
        else $error("place transaction did not yield a result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gasp_pkg::ST_OK)
        |-> (o_place_x == '0 && o_place_y == '0 && o_glyph_index == '0))
        else $error("failed placement reports nonzero position");

endmodule
`default_nettype wire

[rtl/gasp_ctrl.sv]
// Controller FSM of the shelf packer: clearing pass, accept, place, respond.
// Depends on gasp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gasp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_operation,
    input  wire logic           i_out_ready,
    input  wire gasp_pkg::t_sts i_sts,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output gasp_pkg::t_cmd      o_cmd
);

    gasp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gasp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            gasp_pkg::S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = gasp_pkg::S_IDLE;
                end
            end
            gasp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation == gasp_pkg::OP_PIXEL) begin
                        o_cmd.pixel_step = 1'b1;
                    end else begin
                        o_cmd.latch_place = 1'b1;
                        n_state = gasp_pkg::S_PLACE;
                    end
                end
            end
            gasp_pkg::S_PLACE: begin
                o_cmd.place_exec = 1'b1;
                n_state = gasp_pkg::S_RESP;
            end
            gasp_pkg::S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = gasp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gasp_pkg::S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/gasp_dp.sv]
// Datapath of the shelf packer: shelf state, entry table, pixel store and fill
// walker, result register. Depends on gasp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gasp_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gasp_pkg::t_cmd                 i_cmd,
    output gasp_pkg::t_sts                      o_sts,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_atlas_width,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_atlas_height,
    input  wire logic [gasp_pkg::CP_W-1:0]      i_codepoint,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_glyph_width,
    input  wire logic [gasp_pkg::FIELD_W-1:0]   i_glyph_height,
    input  wire logic [gasp_pkg::PIXV_W-1:0]    i_pixel_value,
    output logic [1:0]                          o_status,
    output logic [gasp_pkg::POS_W-1:0]          o_place_x,
    output logic [gasp_pkg::POS_W-1:0]          o_place_y,
    output logic [gasp_pkg::IDX_W-1:0]          o_glyph_index
);

    localparam int FW = gasp_pkg::FIELD_W;
    localparam int PW = gasp_pkg::POS_W;
    localparam int AW = gasp_pkg::PIX_AW;
    localparam int EW = gasp_pkg::ENTRY_AW;

    logic [gasp_pkg::PIXV_W-1:0]  pix_mem [gasp_pkg::PIX_DEPTH];
    logic [gasp_pkg::ENTRY_W-1:0] entry_mem [gasp_pkg::MAX_ENTRIES];

    // shelf state
    logic [FW-1:0] r_cursor, r_shelf_top, r_shelf_h;
    logic [EW:0]   r_used;

    // latched place item
    logic [gasp_pkg::CP_W-1:0] r_cp;
    logic [FW-1:0]             r_gw, r_gh;

    // fill walker
    logic          r_factive;
    logic [PW-1:0] r_org_x, r_org_y;
    logic [FW-1:0] r_fw, r_fh, r_fcol, r_frow;

    // clearing pass and pending pixel write
    logic [AW-1:0]                r_clr_addr;
    logic                         r_pix_we;
    logic [AW-1:0]                r_pix_addr;
    logic [gasp_pkg::PIXV_W-1:0]  r_pix_data;

    // result
    logic [1:0]              r_status;
    logic [PW-1:0]           r_rx, r_ry;
    logic [gasp_pkg::IDX_W-1:0] r_ridx;

    // placement decision
    logic [FW-1:0] wc, hc, top_eff, cur_eff, sh_eff;
    logic          bad_size, full, wrap, fail_h;
    logic [FW:0]   wrap_sum, h_sum;

    // pixel address
    logic [FW:0]     fx, fy, col_inc, row_inc;
    logic            in_range;
    logic [2*FW-1:0] prod;
    logic [AW-1:0]   pix_addr;

    assign wc = gasp_pkg::clamp_dim(i_atlas_width);
    assign hc = gasp_pkg::clamp_dim(i_atlas_height);

    always_comb begin
        bad_size = (r_gw == '0) || (r_gh == '0);
        full     = r_used[EW];
        wrap_sum = {1'b0, r_cursor} + {1'b0, r_gw};
        wrap     = wrap_sum > {1'b0, wc};
        top_eff  = wrap ? (r_shelf_top + r_shelf_h) : r_shelf_top;
        cur_eff  = wrap ? '0 : r_cursor;
        sh_eff   = wrap ? '0 : r_shelf_h;
        h_sum    = {1'b0, top_eff} + {1'b0, r_gh};
        fail_h   = h_sum > {1'b0, hc};
    end

    always_comb begin
        fx       = {2'b00, r_org_x} + {1'b0, r_fcol};
        fy       = {2'b00, r_org_y} + {1'b0, r_frow};
        in_range = (fx < {1'b0, wc}) && (fy < {1'b0, gasp_pkg::DIM_LIMIT});
        prod     = {1'b0, fy[PW-1:0]} * wc;
        pix_addr = prod[AW-1:0] + AW'(fx);
        col_inc  = {1'b0, r_fcol} + 1'b1;
        row_inc  = {1'b0, r_frow} + 1'b1;
    end

    assign o_sts.clear_last = &r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_shelf_top <= '0;
            r_shelf_h   <= '0;
            r_used      <= '0;
            r_factive   <= 1'b0;
            r_fcol      <= '0;
            r_frow      <= '0;
            r_clr_addr  <= '0;
            r_pix_we    <= 1'b0;
        end else begin
            r_pix_we <= 1'b0;
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.pixel_step && r_factive) begin
                r_pix_we <= in_range;
                if (col_inc >= {1'b0, r_fw}) begin
                    r_fcol <= '0;
                    r_frow <= row_inc[FW-1:0];
                    if (row_inc >= {1'b0, r_fh}) begin
                        r_factive <= 1'b0;
                    end
                end else begin
                    r_fcol <= col_inc[FW-1:0];
                end
            end
            if (i_cmd.place_exec) begin
                r_factive <= 1'b0;
                if (!bad_size && !full) begin
                    if (wrap) begin
                        r_shelf_top <= top_eff;
                        r_cursor    <= '0;
                        r_shelf_h   <= '0;
                    end
                    if (!fail_h) begin
                        r_used    <= r_used + 1'b1;
                        r_cursor  <= cur_eff + r_gw;
                        r_shelf_h <= (r_gh > sh_eff) ? r_gh : sh_eff;
                        r_factive <= 1'b1;
                        r_fcol    <= '0;
                        r_frow    <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pixel_step) begin
            r_pix_addr <= pix_addr;
            r_pix_data <= i_pixel_value;
        end
        if (i_cmd.latch_place) begin
            r_cp <= i_codepoint;
            r_gw <= i_glyph_width;
            r_gh <= i_glyph_height;
        end
        if (i_cmd.place_exec) begin
            r_rx     <= '0;
            r_ry     <= '0;
            r_ridx   <= '0;
            r_status <= gasp_pkg::ST_OK;
            if (bad_size) begin
                r_status <= gasp_pkg::ST_INVALID;
            end else if (full || fail_h) begin
                r_status <= gasp_pkg::ST_EXHAUSTED;
            end else begin
                r_rx    <= cur_eff[PW-1:0];
                r_ry    <= top_eff[PW-1:0];
                r_ridx  <= gasp_pkg::IDX_W'(r_used[EW-1:0]);
                r_org_x <= cur_eff[PW-1:0];
                r_org_y <= top_eff[PW-1:0];
                r_fw    <= r_gw;
                r_fh    <= r_gh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place_exec && !bad_size && !full && !fail_h) begin
            entry_mem[r_used[EW-1:0]] <= {r_cp, cur_eff[PW-1:0], top_eff[PW-1:0], r_gw, r_gh};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            pix_mem[r_clr_addr] <= '0;
        end else if (r_pix_we) begin
            pix_mem[r_pix_addr] <= r_pix_data;
        end
    end

    assign o_status      = r_status;
    assign o_place_x     = r_rx;
    assign o_place_y     = r_ry;
    assign o_glyph_index = r_ridx;

endmodule
`default_nettype wire
